// File: rtl/core/crts_pkg.sv
package crts_pkg;

  // request kinds
  localparam logic [1:0] KIND_APPEND     = 2'd0;
  localparam logic [1:0] KIND_REMOVE_ID  = 2'd1;
  localparam logic [1:0] KIND_REMOVE_POS = 2'd2;
  localparam logic [1:0] KIND_SELECT     = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ID_ABSENT = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_POS   = 3'd4;
  localparam logic [2:0] ST_ABOVE     = 3'd5;

  // reported sums saturate at this value (Q22.16)
  localparam int          SUM_BITS = 38;
  localparam logic [37:0] SUM_MAX  = {38{1'b1}};

  // per-cell update controls
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// File: rtl/core/crts_cell.sv
module crts_cell #(
  parameter int SW = 38
) (
  input  logic                clk,
  input  crts_pkg::cell_ctl_t ctl,
  input  logic [31:0]         in_id,
  input  logic [31:0]         in_rate,
  input  logic [SW-1:0]       prev_sum,
  input  logic [31:0]         next_id,
  input  logic [31:0]         next_rate,
  input  logic [SW-1:0]       next_sum,
  input  logic [31:0]         sub_rate,
  input  logic [31:0]         key_id,
  input  logic [37:0]         key_val,
  output logic [31:0]         id_o,
  output logic [31:0]         rate_o,
  output logic [SW-1:0]       sum_o,
  output logic                id_eq,
  output logic                sum_ge
);

  logic [31:0]   id_r;
  logic [31:0]   rate_r;
  logic [SW-1:0] sum_r;
  logic [37:0]   sum_sat;

  // exact running sum kept wide; append builds on the left neighbor,
  // close-up takes the right neighbor less the removed rate
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id_r   <= in_id;
      rate_r <= in_rate;
      sum_r  <= prev_sum + SW'(in_rate);
    end else if (ctl.shift) begin
      id_r   <= next_id;
      rate_r <= next_rate;
      sum_r  <= next_sum - SW'(sub_rate);
    end
  end

  // saturated view of the running sum
  assign sum_sat = (sum_r > SW'(crts_pkg::SUM_MAX)) ? crts_pkg::SUM_MAX : sum_r[37:0];

  // local compares
  assign id_eq  = (id_r == key_id);
  assign sum_ge = (sum_sat >= key_val);

  assign id_o   = id_r;
  assign rate_o = rate_r;
  assign sum_o  = sum_r;

endmodule

// File: rtl/core/cumulative_rate_table_select.sv
// Cumulative rate table with roulette-wheel selection.
// Request channel: pulse start with in_kind and its operands while busy is low;
// the request is taken at that edge and busy rises. Kinds: append an entry,
// remove by id, remove by position, select by search value.
// Result channel: out_strobe is high for one cycle with found_index, status,
// total_propensity and entry_count; the receiver cannot stall it.
// Each table slot is one cell holding id, rate and exact running sum; a
// removal closes up the row in the update step as every cell from the removed
// slot on takes its right neighbor. A request runs through four steps (compare
// in every cell, isolate the first hit, encode index and gather its rate,
// update the row), and no new request is taken while one is in progress. The
// isolate step is one TABLE_DEPTH-bit add.
// Reset empties the table (count and total cleared); slot contents stay
// undefined and are never read while invalid. No clearing pass is needed.
module cumulative_rate_table_select #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_entry_id,
  input  logic [31:0] in_entry_rate,
  input  logic [5:0]  in_slot_position,
  input  logic [37:0] in_search_value,
  output logic        out_strobe,
  output logic [5:0]  out_found_index,
  output logic [2:0]  out_status,
  output logic [37:0] out_total_propensity,
  output logic [6:0]  out_entry_count
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = (32 + IW > 38) ? 32 + IW : 38;

  localparam logic [1:0] PH_MATCH   = 2'd0;
  localparam logic [1:0] PH_ISOLATE = 2'd1;
  localparam logic [1:0] PH_ENCODE  = 2'd2;
  localparam logic [1:0] PH_APPLY   = 2'd3;

  logic                   busy_r;
  logic [1:0]             phase_r;
  logic [CW-1:0]          count_r;
  logic [SW-1:0]          total_r;
  logic [37:0]            total_sat;

  logic [1:0]             kind_q;
  logic [31:0]            id_q;
  logic [31:0]            rate_q;
  logic [5:0]             pos_q;
  logic [37:0]            sval_q;

  logic [TABLE_DEPTH-1:0] hit_nxt;
  logic [TABLE_DEPTH-1:0] hit_r;
  logic [TABLE_DEPTH-1:0] first_r;
  logic [IW-1:0]          idx_nxt;
  logic [IW-1:0]          idx_r;
  logic [31:0]            rate_p_nxt;
  logic [31:0]            rate_p_r;
  logic                   any_r;

  logic                   append_ok;
  logic                   remove_ok;
  logic [2:0]             status_nxt;

  logic                   strobe_r;
  logic [5:0]             idx_out_r;
  logic [2:0]             status_r;

  logic [31:0]            cell_id   [TABLE_DEPTH];
  logic [31:0]            cell_rate [TABLE_DEPTH];
  logic [SW-1:0]          cell_sum  [TABLE_DEPTH];
  logic                   cell_eq   [TABLE_DEPTH];
  logic                   cell_ge   [TABLE_DEPTH];

  assign busy      = busy_r;
  assign total_sat = (total_r > SW'(crts_pkg::SUM_MAX)) ? crts_pkg::SUM_MAX : total_r[37:0];

  // row of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    crts_pkg::cell_ctl_t ctl;
    logic [SW-1:0]       prev_sum;
    logic [31:0]         next_id;
    logic [31:0]         next_rate;
    logic [SW-1:0]       next_sum;

    if (i == 0) begin : g_head
      assign prev_sum = '0;
    end else begin : g_body
      assign prev_sum = cell_sum[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_id   = '0;
      assign next_rate = '0;
      assign next_sum  = '0;
    end else begin : g_link
      assign next_id   = cell_id[i+1];
      assign next_rate = cell_rate[i+1];
      assign next_sum  = cell_sum[i+1];
    end

    assign ctl.load  = (phase_r == PH_APPLY) && append_ok && (32'(i) == 32'(count_r));
    assign ctl.shift = (phase_r == PH_APPLY) && remove_ok && (32'(i) >= 32'(idx_r));

    crts_cell #(.SW(SW)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .in_id     (id_q),
      .in_rate   (rate_q),
      .prev_sum  (prev_sum),
      .next_id   (next_id),
      .next_rate (next_rate),
      .next_sum  (next_sum),
      .sub_rate  (rate_p_r),
      .key_id    (id_q),
      .key_val   (sval_q),
      .id_o      (cell_id[i]),
      .rate_o    (cell_rate[i]),
      .sum_o     (cell_sum[i]),
      .id_eq     (cell_eq[i]),
      .sum_ge    (cell_ge[i])
    );

    // hit per cell, masked by occupancy
    always_comb begin
      hit_nxt[i] = 1'b0;
      if (32'(i) < 32'(count_r)) begin
        case (kind_q)
          crts_pkg::KIND_REMOVE_ID:  hit_nxt[i] = cell_eq[i];
          crts_pkg::KIND_REMOVE_POS: hit_nxt[i] = (32'(pos_q) == 32'(i));
          crts_pkg::KIND_SELECT:     hit_nxt[i] = cell_ge[i];
          default:                   hit_nxt[i] = 1'b0;
        endcase
      end
    end
  end

  // one-hot of the first hit to index and rate
  always_comb begin
    idx_nxt    = '0;
    rate_p_nxt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first_r[i]) begin
        idx_nxt    = idx_nxt | IW'(i);
        rate_p_nxt = rate_p_nxt | cell_rate[i];
      end
    end
  end

  // outcome of the request
  always_comb begin
    append_ok  = 1'b0;
    remove_ok  = 1'b0;
    status_nxt = crts_pkg::ST_OK;
    case (kind_q)
      crts_pkg::KIND_APPEND: begin
        if (32'(count_r) >= 32'(TABLE_DEPTH)) begin
          status_nxt = crts_pkg::ST_FULL;
        end else begin
          append_ok = 1'b1;
        end
      end
      crts_pkg::KIND_REMOVE_ID: begin
        if (!any_r) begin
          status_nxt = crts_pkg::ST_ID_ABSENT;
        end else begin
          remove_ok = 1'b1;
        end
      end
      crts_pkg::KIND_REMOVE_POS: begin
        if (32'(pos_q) >= 32'(count_r)) begin
          status_nxt = crts_pkg::ST_BAD_POS;
        end else begin
          remove_ok = 1'b1;
        end
      end
      default: begin
        if (count_r == '0) begin
          status_nxt = crts_pkg::ST_EMPTY;
        end else if (sval_q > total_sat) begin
          status_nxt = crts_pkg::ST_ABOVE;
        end
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      kind_q <= in_kind;
      id_q   <= in_entry_id;
      rate_q <= in_entry_rate;
      pos_q  <= in_slot_position;
      sval_q <= in_search_value;
    end
  end

  // compare, isolate, encode pipeline registers
  always_ff @(posedge clk) begin
    if (phase_r == PH_MATCH) begin
      hit_r <= hit_nxt;
    end
    if (phase_r == PH_ISOLATE) begin
      first_r <= hit_r & (~hit_r + 1'b1);
      any_r   <= |hit_r;
    end
    if (phase_r == PH_ENCODE) begin
      idx_r    <= idx_nxt;
      rate_p_r <= rate_p_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (busy_r && phase_r == PH_APPLY) begin
      status_r  <= status_nxt;
      idx_out_r <= (status_nxt == crts_pkg::ST_OK && kind_q != crts_pkg::KIND_APPEND) ?
                   6'(idx_r) : 6'd0;
    end
  end

  // sequencer, count and total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      phase_r  <= PH_MATCH;
      count_r  <= '0;
      total_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r  <= 1'b1;
        phase_r <= PH_MATCH;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == PH_APPLY) begin
          busy_r   <= 1'b0;
          strobe_r <= 1'b1;
          if (append_ok) begin
            count_r <= count_r + 1'b1;
            total_r <= total_r + SW'(rate_q);
          end else if (remove_ok) begin
            count_r <= count_r - 1'b1;
            total_r <= total_r - SW'(rate_p_r);
          end
        end
      end
    end
  end

  assign out_strobe           = strobe_r;
  assign out_found_index      = idx_out_r;
  assign out_status           = status_r;
  assign out_total_propensity = total_sat;
  assign out_entry_count      = 7'(count_r);

  // result only right after a request finishes
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!busy_r && $past(busy_r)))
    else $error("result strobe without a finished request");

  // count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // empty table has no propensity
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (total_r == '0))
    else $error("nonzero total on empty table");

  // an idle block holds its entry count
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && !$past(busy_r)) |-> $stable(count_r))
    else $error("count changed while idle");

endmodule

// File: dv/tb_top.sv
module tb_top;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 1230;
  localparam int QUIET_TAIL   = 150;
  localparam int SETTLE       = 12;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_mode_t;

  // table predictor and expected result store
  class rate_table_scoreboard_t;
    typedef struct {
      logic [5:0]  index;
      logic [2:0]  status;
      logic [37:0] total;
      logic [6:0]  count;
    } outcome_t;

    logic [31:0] ids[DEPTH];
    logic [31:0] rates[DEPTH];
    int          count;
    int          failures;
    outcome_t    expected_outcomes[$];

    function new();
      count    = 0;
      failures = 0;
    endfunction

    // running sum of rates up to and including the given slot, saturating
    function logic [37:0] sum_through(int last);
      logic [38:0] acc;
      acc = '0;
      for (int i = 0; i <= last; i++) begin
        acc = acc + rates[i];
        if (acc > {1'b0, crts_pkg::SUM_MAX}) acc = {1'b0, crts_pkg::SUM_MAX};
      end
      return acc[37:0];
    endfunction

    function logic [37:0] total();
      return (count == 0) ? '0 : sum_through(count - 1);
    endfunction

    // later slots move down by one
    function void close_up(int slot);
      for (int i = slot; i < count - 1; i++) begin
        ids[i]   = ids[i + 1];
        rates[i] = rates[i + 1];
      end
      count--;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    function void note_request(logic [1:0] kind, logic [31:0] id, logic [31:0] rate,
                               logic [5:0] slot, logic [37:0] target);
      outcome_t r;
      int       hit;
      r.index  = '0;
      r.status = crts_pkg::ST_OK;
      hit      = -1;
      case (kind)
        crts_pkg::KIND_APPEND: begin
          if (count >= DEPTH) begin
            r.status = crts_pkg::ST_FULL;
          end else begin
            ids[count]   = id;
            rates[count] = rate;
            count++;
          end
        end
        crts_pkg::KIND_REMOVE_ID: begin
          // lowest-indexed match wins among duplicates
          for (int i = 0; i < count; i++) begin
            if (hit < 0 && ids[i] == id) hit = i;
          end
          if (hit < 0) begin
            r.status = crts_pkg::ST_ID_ABSENT;
          end else begin
            r.index = hit[5:0];
            close_up(hit);
          end
        end
        crts_pkg::KIND_REMOVE_POS: begin
          if (int'(slot) >= count) begin
            r.status = crts_pkg::ST_BAD_POS;
          end else begin
            r.index = slot;
            close_up(int'(slot));
          end
        end
        default: begin
          if (count == 0) begin
            r.status = crts_pkg::ST_EMPTY;
          end else if (target > total()) begin
            r.status = crts_pkg::ST_ABOVE;
          end else begin
            // first slot whose running sum reaches the target
            for (int i = 0; i < count; i++) begin
              if (hit < 0 && sum_through(i) >= target) hit = i;
            end
            r.index = hit[5:0];
          end
        end
      endcase
      r.total = total();
      r.count = count[6:0];
      expected_outcomes = {expected_outcomes, r};
    endfunction

    function void check_result(logic [5:0] index, logic [2:0] status, logic [37:0] tot,
                               logic [6:0] cnt);
      outcome_t e;
      if (expected_outcomes.size() == 0) begin
        $error("result with nothing pending: index %0d status %0d", index, status);
        failures++;
        return;
      end
      e = expected_outcomes.pop_front();
      if (index !== e.index) begin
        $error("found_index expected %0d actual %0d", e.index, index);
        failures++;
      end
      if (status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, status);
        failures++;
      end
      if (tot !== e.total) begin
        $error("total_propensity expected %0h actual %0h", e.total, tot);
        failures++;
      end
      if (cnt !== e.count) begin
        $error("entry_count expected %0d actual %0d", e.count, cnt);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [31:0] in_entry_id;
  logic [31:0] in_entry_rate;
  logic [5:0]  in_slot_position;
  logic [37:0] in_search_value;
  logic        out_strobe;
  logic [5:0]  out_found_index;
  logic [2:0]  out_status;
  logic [37:0] out_total_propensity;
  logic [6:0]  out_entry_count;

  rate_table_scoreboard_t rate_table = new();
  int                     cycle_count = 0;
  int                     sent = 0;

  cumulative_rate_table_select #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_entry_id         (in_entry_id),
    .in_entry_rate       (in_entry_rate),
    .in_slot_position    (in_slot_position),
    .in_search_value     (in_search_value),
    .out_strobe          (out_strobe),
    .out_found_index     (out_found_index),
    .out_status          (out_status),
    .out_total_propensity(out_total_propensity),
    .out_entry_count     (out_entry_count)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // check results first, then note a newly taken request
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      rate_table.check_result(out_found_index, out_status, out_total_propensity,
                              out_entry_count);
    end
    if (rst_n && start && !busy) begin
      rate_table.note_request(in_kind, in_entry_id, in_entry_rate, in_slot_position,
                              in_search_value);
    end
  end

  // present a request and hold it until taken
  task automatic issue(input logic [1:0] kind, input logic [31:0] id,
                       input logic [31:0] rate, input logic [5:0] slot,
                       input logic [37:0] target);
    start            <= 1'b1;
    in_kind          <= kind;
    in_entry_id      <= id;
    in_entry_rate    <= rate;
    in_slot_position <= slot;
    in_search_value  <= target;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every pending result is back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (rate_table.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(1, 32'h0001_0000);
      3:       return $urandom & 32'h000F_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // small pool makes duplicate ids common
  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 7))
      0:          return '0;
      1:          return 32'hFFFF_FFFF;
      2, 3, 4, 5: return $urandom_range(0, 15);
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_removal_id();
    if (rate_table.count > 0 && $urandom_range(0, 9) < 7)
      return rate_table.ids[$urandom_range(0, rate_table.count - 1)];
    return pick_id();
  endfunction

  function automatic logic [5:0] pick_slot();
    if (rate_table.count > 0 && $urandom_range(0, 3) != 0)
      return 6'($urandom_range(0, rate_table.count - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  // targets aimed at exact sums, their neighbors and both ends
  function automatic logic [37:0] pick_target();
    logic [37:0] tot;
    logic [37:0] tie;
    logic [63:0] wide;
    tot  = rate_table.total();
    wide = {$urandom, $urandom};
    tie  = (rate_table.count > 0) ?
           rate_table.sum_through($urandom_range(0, rate_table.count - 1)) : '0;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return tot;
      2:       return tot + 38'd1;
      3:       return wide[37:0];
      4, 5:    return tie;
      6:       return (tie != '0) ? tie - 38'd1 : '0;
      default: return 38'(wide % ({26'b0, tot} + 64'd1));
    endcase
  endfunction

  task automatic random_request(input mix_mode_t mode);
    int          roll;
    logic [1:0]  kind;
    logic [31:0] id;
    roll = $urandom_range(0, 99);
    case (mode)
      MIX_GROW: begin
        if (roll < 75)      kind = crts_pkg::KIND_APPEND;
        else if (roll < 95) kind = crts_pkg::KIND_SELECT;
        else if (roll < 98) kind = crts_pkg::KIND_REMOVE_ID;
        else                kind = crts_pkg::KIND_REMOVE_POS;
      end
      MIX_SHRINK: begin
        if (roll < 35)      kind = crts_pkg::KIND_REMOVE_ID;
        else if (roll < 75) kind = crts_pkg::KIND_REMOVE_POS;
        else if (roll < 92) kind = crts_pkg::KIND_SELECT;
        else                kind = crts_pkg::KIND_APPEND;
      end
      default: begin
        if (roll < 30)      kind = crts_pkg::KIND_APPEND;
        else if (roll < 50) kind = crts_pkg::KIND_REMOVE_ID;
        else if (roll < 70) kind = crts_pkg::KIND_REMOVE_POS;
        else                kind = crts_pkg::KIND_SELECT;
      end
    endcase
    id = (kind == crts_pkg::KIND_REMOVE_ID) ? pick_removal_id() : pick_id();
    issue(kind, id, pick_rate(), pick_slot(), pick_target());
    sent++;
  endtask

  // grow and shrink phases run to full or empty plus a few extra requests
  task automatic run_phase(input mix_mode_t mode, input int length);
    int n;
    bit idle_on;
    bit reached;
    n       = 0;
    reached = 0;
    idle_on = ($urandom_range(0, 2) != 0);
    while (n < length && sent < RANDOM_ITEMS) begin
      if (!reached && ((mode == MIX_GROW && rate_table.count == DEPTH) ||
                       (mode == MIX_SHRINK && rate_table.count == 0))) begin
        reached = 1;
        length  = n + 4;
      end
      if (idle_on && sent < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        pause_cycles($urandom_range(1, 16));
      random_request(mode);
      n++;
    end
  endtask

  initial begin
    int phase;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_kind          = crts_pkg::KIND_APPEND;
    in_entry_id      = '0;
    in_entry_rate    = '0;
    in_slot_position = '0;
    in_search_value  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table errors
    issue(crts_pkg::KIND_SELECT,     32'd0, 32'd0, 6'd0, 38'd0);
    issue(crts_pkg::KIND_REMOVE_ID,  32'd0, 32'd0, 6'd0, 38'd0);
    issue(crts_pkg::KIND_REMOVE_POS, 32'd0, 32'd0, 6'd0, 38'd0);
    // zero rate at slot zero is still chosen for a zero target
    issue(crts_pkg::KIND_APPEND,     32'd5, 32'd0, 6'd0, 38'd0);
    issue(crts_pkg::KIND_SELECT,     32'd0, 32'd0, 6'd0, 38'd0);
    issue(crts_pkg::KIND_SELECT,     32'd0, 32'd0, 6'd0, 38'd1);
    // max rate, duplicate id, trailing zero rate
    issue(crts_pkg::KIND_APPEND,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 38'd0);
    issue(crts_pkg::KIND_APPEND,     32'd5, 32'd1, 6'd0, 38'd0);
    issue(crts_pkg::KIND_APPEND,     32'd0, 32'd0, 6'd0, 38'd0);
    // ties, exact total, just above total, largest target
    issue(crts_pkg::KIND_SELECT,     32'd0, 32'd0, 6'd0, 38'hFFFF_FFFF);
    issue(crts_pkg::KIND_SELECT,     32'd0, 32'd0, 6'd0, 38'h1_0000_0000);
    issue(crts_pkg::KIND_SELECT,     32'd0, 32'd0, 6'd0, 38'h1_0000_0001);
    issue(crts_pkg::KIND_SELECT,     32'd0, 32'd0, 6'd0, crts_pkg::SUM_MAX);
    // bad positions, duplicate removal, absent id
    issue(crts_pkg::KIND_REMOVE_POS, 32'd0, 32'd0, 6'd63, 38'd0);
    issue(crts_pkg::KIND_REMOVE_POS, 32'd0, 32'd0, 6'd4, 38'd0);
    issue(crts_pkg::KIND_REMOVE_ID,  32'd5, 32'd0, 6'd0, 38'd0);
    issue(crts_pkg::KIND_REMOVE_ID,  32'd12345, 32'd0, 6'd0, 38'd0);
    issue(crts_pkg::KIND_SELECT,     32'd0, 32'd0, 6'd0, 38'd1);
    issue(crts_pkg::KIND_REMOVE_POS, 32'd0, 32'd0, 6'd1, 38'd0);
    issue(crts_pkg::KIND_REMOVE_POS, 32'd0, 32'd0, 6'd0, 38'd0);
    issue(crts_pkg::KIND_REMOVE_POS, 32'd0, 32'd0, 6'd0, 38'd0);
    issue(crts_pkg::KIND_SELECT,     32'd0, 32'd0, 6'd0, 38'd0);
    drain();

    // random phases cycling through fill, mixed, empty and mixed traffic
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0:       run_phase(MIX_GROW, 250);
        2:       run_phase(MIX_SHRINK, 250);
        default: run_phase(MIX_BALANCED, $urandom_range(40, 120));
      endcase
      if (phase % 5 == 3) drain();
      phase++;
    end

    drain();
    if (rate_table.failures == 0 && rate_table.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/crts_pkg.sv
rtl/core/crts_cell.sv
rtl/core/cumulative_rate_table_select.sv
dv/tb_top.sv
